// ----- rtl/limit_order_book_engine_defines.svh -----
// Assertion helpers used by the order book datapath.
`ifndef LIMIT_ORDER_BOOK_ENGINE_DEFINES_SVH
`define LIMIT_ORDER_BOOK_ENGINE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define LOBE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define LOBE_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lobe_pkg.sv -----
// ----------------------------------------------------------------------------
// lobe_pkg
// Shared constants and types of the limit order book engine.
// ----------------------------------------------------------------------------
package lobe_pkg;

    localparam int DEF_MAX_ORDERS = 64;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_EXECUTE = 3'd1;
    localparam logic [2:0] CMD_CANCEL  = 3'd2;
    localparam logic [2:0] CMD_REPLACE = 3'd3;
    localparam logic [2:0] CMD_MATCH   = 3'd4;
    localparam logic [2:0] CMD_PRINT   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic apply;
        logic load_out;
    } lobe_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic last;
    } lobe_sts_t;

endpackage

// ----- rtl/lobe_req_if.sv -----
// ----------------------------------------------------------------------------
// lobe_req_if
// Command channel of the order book: valid/ready with one command word.
// ----------------------------------------------------------------------------
interface lobe_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [63:0]        order_id;
    logic [63:0]        new_order_id;
    logic signed [31:0] price;
    logic [31:0]        quantity;
    logic               side;
    logic               has_limit;
    logic signed [31:0] price_cap;

    modport source (output valid, cmd, order_id, new_order_id, price, quantity, side,
                    has_limit, price_cap, input ready);
    modport sink (input valid, cmd, order_id, new_order_id, price, quantity, side,
                  has_limit, price_cap, output ready);
endinterface

// ----- rtl/lobe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lobe_rsp_if
// Result channel of the order book: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface lobe_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        trade_valid;
    logic [63:0] maker_id;
    logic [30:0] trade_price;
    logic [31:0] fill_qty;
    logic [63:0] trade_seq;
    logic        last;
    logic [30:0] top_bid_price;
    logic [30:0] top_ask_price;
    logic [37:0] best_bid_qty;
    logic [37:0] best_ask_qty;
    logic [6:0]  resting_orders;

    modport source (output valid, accepted, trade_valid, maker_id, trade_price,
                    fill_qty, trade_seq, last, top_bid_price, top_ask_price,
                    best_bid_qty, best_ask_qty, resting_orders, input ready);
    modport sink (input valid, accepted, trade_valid, maker_id, trade_price,
                  fill_qty, trade_seq, last, top_bid_price, top_ask_price,
                  best_bid_qty, best_ask_qty, resting_orders, output ready);
endinterface

// ----- rtl/limit_order_book_engine.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_engine
// Order-level limit order book with price-time priority.
// ----------------------------------------------------------------------------
// Commands arrive on the req channel, one word per command; results leave on
// the rsp channel. Every command yields one result word, except a match that
// fills several makers, which yields one word per fill with last on the final
// one. Every word carries the top of book as it stands after its effect.
// A command runs as one sweep over the order table to look up ids and a free
// slot, one update step, and a second sweep that recomputes the best bid and
// ask; the first result word is then valid. Each further fill of a match
// repeats the update and the second sweep. The sweeps read one slot a cycle
// through a single read port. A new command is taken only after the last
// result word of the previous one has been taken.
// Reset empties the book and clears the sequence counter; it is ready at once.
// While the receiver stalls, the result word is held and the block waits.
// ----------------------------------------------------------------------------
module limit_order_book_engine
#(
    parameter int MAX_ORDERS = lobe_pkg::DEF_MAX_ORDERS
)
(
    input  logic       clk,
    input  logic       rst_n,
    lobe_req_if.sink   req,
    lobe_rsp_if.source rsp
);

    lobe_pkg::lobe_ctl_t ctl;
    lobe_pkg::lobe_sts_t sts;
    logic                req_ready;
    logic                rsp_valid;

    lobe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    lobe_dp #(.MAX_ORDERS(MAX_ORDERS)) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .sts   (sts)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

// ----- rtl/lobe_ctrl.sv -----
// ----------------------------------------------------------------------------
// lobe_ctrl
// Sequencer: lookup scan, apply, top-of-book scan, result handoff.
// ----------------------------------------------------------------------------
module lobe_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output lobe_pkg::lobe_ctl_t ctl,
    input  lobe_pkg::lobe_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load_in    = 1'b1;
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                ctl.apply      = 1'b1;
                ctl.scan_start = 1'b1;
                state_next     = S_SCAN2;
            end
            S_SCAN2:
            begin
                if (sts.scan_done)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = sts.last ? S_IDLE : S_APPLY;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/lobe_dp.sv -----
// ----------------------------------------------------------------------------
// lobe_dp
// Order table, scan unit, update logic and result register.
// ----------------------------------------------------------------------------
`include "limit_order_book_engine_defines.svh"

module lobe_dp
#(
    parameter int MAX_ORDERS = lobe_pkg::DEF_MAX_ORDERS
)
(
    input  logic                clk,
    input  logic                rst_n,
    lobe_req_if.sink            req,
    lobe_rsp_if.source          rsp,
    input  lobe_pkg::lobe_ctl_t ctl,
    output lobe_pkg::lobe_sts_t sts
);

    localparam int IW = $clog2(MAX_ORDERS);
    localparam int CW = $clog2(MAX_ORDERS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ORDERS - 1);

    // Latched command word.
    logic [2:0]         cmd_reg;
    logic [63:0]        oid_reg;
    logic [63:0]        nid_reg;
    logic signed [31:0] price_reg;
    logic [31:0]        qty_reg;
    logic               side_reg;
    logic               hlim_reg;
    logic signed [31:0] lim_reg;

    // Order table.
    logic [63:0] mem_id    [MAX_ORDERS];
    logic        mem_side  [MAX_ORDERS];
    logic [30:0] mem_price [MAX_ORDERS];
    logic [31:0] mem_rem   [MAX_ORDERS];
    logic [63:0] mem_seq   [MAX_ORDERS];
    logic [MAX_ORDERS-1:0] valid_reg;
    logic [63:0] seq_reg;
    logic [6:0]  count_reg;

    // Scan unit.
    logic          act_reg;
    logic [IW-1:0] addr_reg;
    logic          pv_reg;
    logic [IW-1:0] pidx_reg;
    logic          done_reg;
    logic          rd_v_reg;
    logic [63:0]   rd_id_reg;
    logic          rd_side_reg;
    logic [30:0]   rd_price_reg;
    logic [31:0]   rd_rem_reg;
    logic [63:0]   rd_seq_reg;

    // Scan results.
    logic          found_reg;
    logic [IW-1:0] found_idx_reg;
    logic [31:0]   found_rem_reg;
    logic          nfound_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          bst_v_reg     [2];
    logic [IW-1:0] bst_idx_reg   [2];
    logic [30:0]   bst_price_reg [2];
    logic [63:0]   bst_seq_reg   [2];
    logic [37:0]   bst_qty_reg   [2];
    logic [31:0]   bst_rem_reg   [2];
    logic [63:0]   bst_id_reg    [2];

    // Match progress and trade capture.
    logic [31:0]   qrem_reg;
    logic [CW-1:0] n_reg;
    logic          did_reg;
    logic          ok_reg;
    logic [63:0]   tr_id_reg;
    logic [30:0]   tr_price_reg;
    logic [31:0]   tr_qty_reg;
    logic [63:0]   tr_seq_reg;

    // Result register.
    logic        o_acc_reg;
    logic        o_tv_reg;
    logic        o_last_reg;
    logic [30:0] o_bbp_reg;
    logic [30:0] o_bap_reg;
    logic [37:0] o_bbq_reg;
    logic [37:0] o_baq_reg;
    logic [6:0]  o_cnt_reg;

    // Update decode.
    logic          is_match;
    logic          ms;
    logic          lim_ok;
    logic          trade_ok;
    logic signed [31:0] bp;
    logic          ok;
    logic          we_full;
    logic          we_rem;
    logic [IW-1:0] waddr;
    logic [31:0]   wrem;
    logic [31:0]   amt;
    logic          vset;
    logic          vclr;
    logic [IW-1:0] vclr_idx;
    logic [MAX_ORDERS-1:0] valid_next;
    logic [6:0]    count_next;
    logic [63:0]   seq_next;

    assign is_match = cmd_reg == lobe_pkg::CMD_MATCH;
    assign ms       = ~side_reg;
    assign bp       = $signed({1'b0, bst_price_reg[ms]});
    assign lim_ok   = !hlim_reg || (side_reg ? !(bp < lim_reg) : !(bp > lim_reg));
    assign trade_ok = (qrem_reg != 32'd0) && (n_reg < CW'(MAX_ORDERS))
                      && bst_v_reg[ms] && lim_ok;

    always_comb
    begin
        ok         = 1'b0;
        we_full    = 1'b0;
        we_rem     = 1'b0;
        waddr      = free_idx_reg;
        wrem       = qty_reg;
        amt        = 32'd0;
        vset       = 1'b0;
        vclr       = 1'b0;
        vclr_idx   = found_idx_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        case (cmd_reg)
            lobe_pkg::CMD_ADD:
            begin
                ok = (oid_reg != 64'd0) && (price_reg > 32'sd0) && (qty_reg != 32'd0)
                     && !found_reg && free_reg;
                if (ok)
                begin
                    we_full    = 1'b1;
                    vset       = 1'b1;
                    seq_next   = seq_reg + 64'd1;
                    count_next = count_reg + 7'd1;
                end
            end
            lobe_pkg::CMD_EXECUTE, lobe_pkg::CMD_CANCEL:
            begin
                ok    = (oid_reg != 64'd0) && (qty_reg != 32'd0) && found_reg;
                amt   = (qty_reg < found_rem_reg) ? qty_reg : found_rem_reg;
                waddr = found_idx_reg;
                wrem  = found_rem_reg - amt;
                if (ok)
                begin
                    we_rem = 1'b1;
                    if (wrem == 32'd0)
                    begin
                        vclr       = 1'b1;
                        count_next = count_reg - 7'd1;
                    end
                end
            end
            lobe_pkg::CMD_REPLACE:
            begin
                ok = (oid_reg != 64'd0) && (nid_reg != 64'd0) && (oid_reg != nid_reg)
                     && (price_reg > 32'sd0) && (qty_reg != 32'd0) && found_reg
                     && !nfound_reg;
                // The freed slot of the old order may be the lowest free one.
                waddr = (free_reg && (free_idx_reg < found_idx_reg)) ? free_idx_reg
                                                                     : found_idx_reg;
                if (ok)
                begin
                    we_full  = 1'b1;
                    vclr     = 1'b1;
                    vset     = 1'b1;
                    seq_next = seq_reg + 64'd1;
                end
            end
            lobe_pkg::CMD_MATCH:
            begin
                ok       = 1'b1;
                amt      = (qrem_reg < bst_rem_reg[ms]) ? qrem_reg : bst_rem_reg[ms];
                waddr    = bst_idx_reg[ms];
                vclr_idx = bst_idx_reg[ms];
                wrem     = bst_rem_reg[ms] - amt;
                if (trade_ok)
                begin
                    we_rem   = 1'b1;
                    seq_next = seq_reg + 64'd1;
                    if (wrem == 32'd0)
                    begin
                        vclr       = 1'b1;
                        count_next = count_reg - 7'd1;
                    end
                end
            end
            lobe_pkg::CMD_PRINT:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // On a replace the new order may land in the slot that the old one frees.
    always_comb
    begin
        valid_next = valid_reg;
        if (vclr)
        begin
            valid_next[vclr_idx] = 1'b0;
        end
        if (vset)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    // Table storage.
    always_ff @(posedge clk)
    begin
        if (ctl.apply && we_full)
        begin
            mem_id[waddr]    <= (cmd_reg == lobe_pkg::CMD_ADD) ? oid_reg : nid_reg;
            mem_side[waddr]  <= side_reg;
            mem_price[waddr] <= price_reg[30:0];
            mem_seq[waddr]   <= seq_next;
        end
        if (ctl.apply && (we_full || we_rem))
        begin
            mem_rem[waddr] <= wrem;
        end
        rd_id_reg    <= mem_id[addr_reg];
        rd_side_reg  <= mem_side[addr_reg];
        rd_price_reg <= mem_price[addr_reg];
        rd_rem_reg   <= mem_rem[addr_reg];
        rd_seq_reg   <= mem_seq[addr_reg];
    end

    // Control state: valid bits, counters, scan sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seq_reg   <= '0;
            count_reg <= '0;
            act_reg   <= 1'b0;
            addr_reg  <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            rd_v_reg  <= 1'b0;
            qrem_reg  <= '0;
            n_reg     <= '0;
            did_reg   <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.apply)
            begin
                valid_reg <= valid_next;
                seq_reg   <= seq_next;
                count_reg <= count_next;
                ok_reg    <= ok;
                if (is_match && trade_ok)
                begin
                    qrem_reg <= qrem_reg - amt;
                    n_reg    <= n_reg + CW'(1);
                    did_reg  <= 1'b1;
                end
            end
            if (ctl.load_in)
            begin
                qrem_reg <= req.quantity;
                n_reg    <= '0;
                did_reg  <= 1'b0;
            end
            rd_v_reg <= valid_reg[addr_reg];
            pv_reg   <= act_reg;
            done_reg <= pv_reg && (pidx_reg == LAST_IDX);
            if (ctl.scan_start)
            begin
                act_reg  <= 1'b1;
                addr_reg <= '0;
            end
            else if (act_reg)
            begin
                if (addr_reg == LAST_IDX)
                begin
                    act_reg <= 1'b0;
                end
                else
                begin
                    addr_reg <= addr_reg + IW'(1);
                end
            end
        end
    end

    // Input latch, scan accumulation, trade capture, result register.
    always_ff @(posedge clk)
    begin
        pidx_reg <= addr_reg;
        if (ctl.load_in)
        begin
            cmd_reg      <= req.cmd;
            oid_reg      <= req.order_id;
            nid_reg      <= req.new_order_id;
            price_reg    <= req.price;
            qty_reg      <= req.quantity;
            side_reg     <= req.side;
            hlim_reg     <= req.has_limit;
            lim_reg      <= req.price_cap;
            tr_id_reg    <= '0;
            tr_price_reg <= '0;
            tr_qty_reg   <= '0;
            tr_seq_reg   <= '0;
        end
        if (ctl.apply && is_match && trade_ok)
        begin
            tr_id_reg    <= bst_id_reg[ms];
            tr_price_reg <= bst_price_reg[ms];
            tr_qty_reg   <= amt;
            tr_seq_reg   <= seq_next;
        end
        if (ctl.scan_start)
        begin
            found_reg  <= 1'b0;
            nfound_reg <= 1'b0;
            free_reg   <= 1'b0;
            bst_v_reg[0] <= 1'b0;
            bst_v_reg[1] <= 1'b0;
        end
        else if (pv_reg)
        begin
            if (!rd_v_reg)
            begin
                if (!free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= pidx_reg;
                end
            end
            else
            begin
                if (rd_id_reg == oid_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= pidx_reg;
                    found_rem_reg <= rd_rem_reg;
                end
                if (rd_id_reg == nid_reg)
                begin
                    nfound_reg <= 1'b1;
                end
                // A better price restarts the level total; an equal price adds to it
                // and the older order keeps the head of the queue.
                if (!bst_v_reg[rd_side_reg] ||
                    ((rd_price_reg != bst_price_reg[rd_side_reg]) &&
                     (rd_side_reg ? (rd_price_reg < bst_price_reg[rd_side_reg])
                                  : (rd_price_reg > bst_price_reg[rd_side_reg]))))
                begin
                    bst_v_reg[rd_side_reg]     <= 1'b1;
                    bst_idx_reg[rd_side_reg]   <= pidx_reg;
                    bst_price_reg[rd_side_reg] <= rd_price_reg;
                    bst_seq_reg[rd_side_reg]   <= rd_seq_reg;
                    bst_rem_reg[rd_side_reg]   <= rd_rem_reg;
                    bst_id_reg[rd_side_reg]    <= rd_id_reg;
                    bst_qty_reg[rd_side_reg]   <= {6'd0, rd_rem_reg};
                end
                else if (rd_price_reg == bst_price_reg[rd_side_reg])
                begin
                    bst_qty_reg[rd_side_reg] <= bst_qty_reg[rd_side_reg]
                                                + {6'd0, rd_rem_reg};
                    if (rd_seq_reg < bst_seq_reg[rd_side_reg])
                    begin
                        bst_idx_reg[rd_side_reg] <= pidx_reg;
                        bst_seq_reg[rd_side_reg] <= rd_seq_reg;
                        bst_rem_reg[rd_side_reg] <= rd_rem_reg;
                        bst_id_reg[rd_side_reg]  <= rd_id_reg;
                    end
                end
            end
        end
        if (ctl.load_out)
        begin
            o_acc_reg  <= is_match ? 1'b1 : ok_reg;
            o_tv_reg   <= is_match && did_reg;
            o_last_reg <= (is_match && did_reg) ? !trade_ok : 1'b1;
            o_bbp_reg  <= bst_v_reg[0] ? bst_price_reg[0] : 31'd0;
            o_bap_reg  <= bst_v_reg[1] ? bst_price_reg[1] : 31'd0;
            o_bbq_reg  <= bst_v_reg[0] ? bst_qty_reg[0] : 38'd0;
            o_baq_reg  <= bst_v_reg[1] ? bst_qty_reg[1] : 38'd0;
            o_cnt_reg  <= count_reg;
        end
    end

    assign sts.scan_done = done_reg;
    assign sts.last      = o_last_reg;

    assign rsp.accepted       = o_acc_reg;
    assign rsp.trade_valid    = o_tv_reg;
    assign rsp.maker_id       = tr_id_reg;
    assign rsp.trade_price    = tr_price_reg;
    assign rsp.fill_qty       = tr_qty_reg;
    assign rsp.trade_seq      = tr_seq_reg;
    assign rsp.last           = o_last_reg;
    assign rsp.top_bid_price  = o_bbp_reg;
    assign rsp.top_ask_price  = o_bap_reg;
    assign rsp.best_bid_qty   = o_bbq_reg;
    assign rsp.best_ask_qty   = o_baq_reg;
    assign rsp.resting_orders = o_cnt_reg;

    `LOBE_ASSERT_ALWAYS(a_count_matches_valid,
        count_reg == 7'($countones(valid_reg)), "order count differs from valid slots")
    `LOBE_ASSERT_ALWAYS(a_done_after_sweep, !(done_reg && act_reg),
        "scan reported done while still reading")
    `LOBE_ASSERT_NEXT(a_trade_nonzero, ctl.apply && is_match && trade_ok,
        tr_qty_reg != 32'd0, "match produced an empty fill")

endmodule

// ----- sim/lobe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobe_checker
// Watches both channels of the order book, keeps its own copy of the book,
// predicts every result word and compares it field by field in order.
// ----------------------------------------------------------------------------
module lobe_checker
(
    input  logic clk,
    input  logic rst_n,
    lobe_req_if  req,
    lobe_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    localparam int SLOTS = lobe_pkg::DEF_MAX_ORDERS;

    typedef struct {
        logic        accepted;
        logic        trade_valid;
        logic [63:0] maker_id;
        logic [30:0] trade_price;
        logic [31:0] fill_qty;
        logic [63:0] trade_seq;
        logic        last;
        logic [30:0] top_bid_price;
        logic [30:0] top_ask_price;
        logic [37:0] best_bid_qty;
        logic [37:0] best_ask_qty;
        logic [6:0]  resting_orders;
    } book_word_t;

    book_word_t  expected_words[$];

    bit          live[SLOTS];
    logic [63:0] ord_id[SLOTS];
    logic        ord_side[SLOTS];
    logic [30:0] ord_px[SLOTS];
    logic [31:0] ord_left[SLOTS];
    logic [63:0] ord_seq[SLOTS];
    logic [63:0] seq_ctr;
    logic [6:0]  resting;

    function automatic int lookup_order(logic [63:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && ord_id[i] == id)
                return i;
        return -1;
    endfunction

    // Best price first, then the oldest sequence number at that price.
    function automatic int best_order(logic s);
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!live[i] || ord_side[i] != s)
                continue;
            if (b < 0)
                b = i;
            else if (ord_px[i] != ord_px[b])
            begin
                if (s == 1'b0 ? ord_px[i] > ord_px[b] : ord_px[i] < ord_px[b])
                    b = i;
            end
            else if (ord_seq[i] < ord_seq[b])
                b = i;
        end
        return b;
    endfunction

    function automatic void level_top(logic s, output logic [30:0] px,
                                      output logic [37:0] qty);
        int b;
        b = best_order(s);
        px = '0;
        qty = '0;
        if (b < 0)
            return;
        px = ord_px[b];
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && ord_side[i] == s && ord_px[i] == px)
                qty += 38'(ord_left[i]);
    endfunction

    function automatic book_word_t book_word(logic acc, logic tv, logic [63:0] maker,
                                             logic [30:0] px, logic [31:0] qty,
                                             logic [63:0] sq, logic lst);
        book_word_t w;
        w.accepted = acc;
        w.trade_valid = tv;
        w.maker_id = maker;
        w.trade_price = px;
        w.fill_qty = qty;
        w.trade_seq = sq;
        w.last = lst;
        level_top(1'b0, w.top_bid_price, w.best_bid_qty);
        level_top(1'b1, w.top_ask_price, w.best_ask_qty);
        w.resting_orders = resting;
        return w;
    endfunction

    function automatic void shrink_order(int i, logic [31:0] q);
        ord_left[i] -= (q < ord_left[i]) ? q : ord_left[i];
        if (ord_left[i] == 0)
        begin
            live[i] = 1'b0;
            resting--;
        end
    endfunction

    function automatic bit rest_order(logic [63:0] id, logic signed [31:0] px,
                                      logic [31:0] qty, logic s);
        int f;
        f = -1;
        if (id == 0 || px <= 0 || qty == 0 || lookup_order(id) >= 0)
            return 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!live[i])
                f = i;
        if (f < 0)
            return 1'b0;
        seq_ctr++;
        live[f] = 1'b1;
        ord_id[f] = id;
        ord_side[f] = s;
        ord_px[f] = px[30:0];
        ord_left[f] = qty;
        ord_seq[f] = seq_ctr;
        resting++;
        return 1'b1;
    endfunction

    function automatic void apply_command();
        bit          ok;
        int          i;
        int          fills;
        logic [31:0] left;
        logic [31:0] amt;
        logic [63:0] mid;
        logic [30:0] mpx;
        longint      p;
        longint      lim;
        ok = 1'b0;
        fills = 0;
        left = req.quantity;
        lim = longint'(req.price_cap);
        case (req.cmd)
            lobe_pkg::CMD_ADD:
                ok = rest_order(req.order_id, req.price, req.quantity, req.side);
            lobe_pkg::CMD_EXECUTE, lobe_pkg::CMD_CANCEL:
                if (req.order_id != 0 && req.quantity != 0)
                begin
                    i = lookup_order(req.order_id);
                    if (i >= 0)
                    begin
                        shrink_order(i, req.quantity);
                        ok = 1'b1;
                    end
                end
            lobe_pkg::CMD_REPLACE:
                if (req.order_id != 0 && req.new_order_id != 0
                    && req.order_id != req.new_order_id && req.price > 0
                    && req.quantity != 0)
                begin
                    i = lookup_order(req.order_id);
                    if (i >= 0 && lookup_order(req.new_order_id) < 0)
                    begin
                        shrink_order(i, ord_left[i]);
                        ok = rest_order(req.new_order_id, req.price, req.quantity,
                                        req.side);
                    end
                end
            lobe_pkg::CMD_MATCH:
            begin
                while (left > 0 && fills < SLOTS)
                begin
                    i = best_order(!req.side);
                    if (i < 0)
                        break;
                    p = longint'(ord_px[i]);
                    if (req.has_limit && (req.side == 1'b0 ? p > lim : p < lim))
                        break;
                    amt = (left < ord_left[i]) ? left : ord_left[i];
                    mid = ord_id[i];
                    mpx = ord_px[i];
                    shrink_order(i, amt);
                    left -= amt;
                    seq_ctr++;
                    expected_words.insert(expected_words.size(),
                                          book_word(1'b1, 1'b1, mid, mpx, amt,
                                                    seq_ctr, 1'b0));
                    fills++;
                end
                if (fills > 0)
                begin
                    expected_words[$].last = 1'b1;
                    return;
                end
                ok = 1'b1;
            end
            lobe_pkg::CMD_PRINT: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        expected_words.insert(expected_words.size(),
                              book_word(ok, 1'b0, '0, '0, '0, '0, 1'b1));
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        book_word_t e;
        if (!rst_n)
        begin
            foreach (live[i])
                live[i] = 1'b0;
            seq_ctr = '0;
            resting = '0;
            expected_words.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    check_field("accepted", e.accepted, rsp.accepted);
                    check_field("trade_valid", e.trade_valid, rsp.trade_valid);
                    check_field("maker_id", e.maker_id, rsp.maker_id);
                    check_field("trade_price", e.trade_price, rsp.trade_price);
                    check_field("fill_qty", e.fill_qty, rsp.fill_qty);
                    check_field("trade_seq", e.trade_seq, rsp.trade_seq);
                    check_field("last", e.last, rsp.last);
                    check_field("top_bid_price", e.top_bid_price, rsp.top_bid_price);
                    check_field("top_ask_price", e.top_ask_price, rsp.top_ask_price);
                    check_field("best_bid_qty", e.best_bid_qty, rsp.best_bid_qty);
                    check_field("best_ask_qty", e.best_ask_qty, rsp.best_ask_qty);
                    check_field("resting_orders", e.resting_orders, rsp.resting_orders);
                end
            end
            if (req.valid && req.ready)
                apply_command();
            pending = expected_words.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Order book testbench: directed commands, a table fill, random traffic, two sweeps.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

    localparam longint CYCLE_LIMIT = 20000000;

    // Command codes that the block does not know.
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    logic   clk;
    logic   rst_n;
    int     errors;
    int     pending;
    longint cycles = 0;
    bit     calm;

    lobe_req_if req ();
    lobe_rsp_if rsp ();

    limit_order_book_engine DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    lobe_checker u_checker (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                            .errors(errors), .pending(pending));

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // The receiver stalls at random except during the calm stretch.
    always @(negedge clk)
        rsp.ready = calm || ($urandom_range(0, 99) >= 20);

    task automatic send(logic [2:0] cmd, logic [63:0] id, logic [63:0] nid,
                        logic [31:0] px, logic [31:0] qty, logic s,
                        logic hl = 1'b0, logic [31:0] lim = '0);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req.cmd = cmd;
        req.order_id = id;
        req.new_order_id = nid;
        req.price = px;
        req.quantity = qty;
        req.side = s;
        req.has_limit = hl;
        req.price_cap = lim;
        req.valid = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    function automatic logic [63:0] any_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 7)
            return {$urandom, $urandom};
        return 64'($urandom_range(1, 120));
    endfunction

    function automatic logic [31:0] any_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 32'h7FFF_FFFF;
        if (r < 4)
            return '0;
        if (r < 8)
            return $urandom;
        return 32'($urandom_range(95, 115));
    endfunction

    function automatic logic [31:0] any_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 7)
            return $urandom;
        return 32'($urandom_range(1, 300));
    endfunction

    task automatic random_command();
        int          r;
        logic [2:0]  c;
        logic [31:0] lim;
        r = $urandom_range(0, 99);
        if (r < 35)
            c = lobe_pkg::CMD_ADD;
        else if (r < 50)
            c = lobe_pkg::CMD_EXECUTE;
        else if (r < 62)
            c = lobe_pkg::CMD_CANCEL;
        else if (r < 74)
            c = lobe_pkg::CMD_REPLACE;
        else if (r < 92)
            c = lobe_pkg::CMD_MATCH;
        else if (r < 97)
            c = lobe_pkg::CMD_PRINT;
        else
            c = ($urandom_range(0, 1) == 0) ? CMD_BAD_LO : CMD_BAD_HI;
        lim = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(95, 115));
        send(c, any_id(), any_id(), any_price(), any_qty(), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), lim);
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        req.valid = 1'b0;
        req.cmd = lobe_pkg::CMD_PRINT;
        req.order_id = '0;
        req.new_order_id = '0;
        req.price = '0;
        req.quantity = '0;
        req.side = 1'b0;
        req.has_limit = 1'b0;
        req.price_cap = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: rejects, partial and oversized reductions, replace, sweeps.
        send(lobe_pkg::CMD_MATCH, 64'd1, '0, '0, 32'd10, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'd1, '0, 32'd100, 32'd50, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'd2, '0, 32'd1, 32'd20, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             1'b1);
        send(lobe_pkg::CMD_ADD, 64'd3, '0, 32'd105, 32'd30, 1'b1);
        send(lobe_pkg::CMD_ADD, 64'd4, '0, 32'd105, 32'd40, 1'b1);
        send(lobe_pkg::CMD_ADD, 64'd5, '0, '0, 32'd10, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'd5, '0, 32'h8000_0000, 32'd10, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'd5, '0, 32'd100, '0, 1'b0);
        send(lobe_pkg::CMD_ADD, '0, '0, 32'd100, 32'd10, 1'b0);
        send(lobe_pkg::CMD_ADD, 64'd1, '0, 32'd99, 32'd10, 1'b1);
        send(lobe_pkg::CMD_EXECUTE, 64'd1, '0, '0, 32'd5, 1'b0);
        send(lobe_pkg::CMD_EXECUTE, 64'd2, '0, '0, 32'hFFFF_FFFF, 1'b0);
        send(lobe_pkg::CMD_CANCEL, 64'd77, '0, '0, 32'd5, 1'b0);
        send(lobe_pkg::CMD_CANCEL, 64'd1, '0, '0, '0, 1'b0);
        send(lobe_pkg::CMD_REPLACE, 64'd1, 64'd1, 32'd101, 32'd10, 1'b0);
        send(lobe_pkg::CMD_REPLACE, 64'd1, 64'd3, 32'd101, 32'd10, 1'b0);
        send(lobe_pkg::CMD_REPLACE, 64'd1, 64'd6, 32'd101, 32'd60, 1'b0);
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, 32'd100, 1'b0, 1'b1, 32'd104);
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, '0, 1'b0);
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, 32'd50, 1'b0, 1'b1, 32'd105);
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, 32'd70, 1'b1);
        send(lobe_pkg::CMD_PRINT, 64'd9, '0, '0, 32'd9, 1'b0);
        send(lobe_pkg::CMD_CANCEL, 64'd6, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd60,
             1'b1, 1'b1, 32'hFFFF_FFFF);
        send(CMD_BAD_LO, 64'd1, '0, 32'd100, 32'd1, 1'b0);
        send(CMD_BAD_HI, 64'd1, '0, 32'd100, 32'd1, 1'b0);

        // Hold off until the book has answered everything so far.
        while (pending != 0)
            @(negedge clk);

        // Fill the table past its size so that the extra adds are refused.
        for (int k = 0; k < 70; k++)
            send(lobe_pkg::CMD_ADD, 64'(1000 + k), '0, 32'($urandom_range(95, 115)),
                 ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 500)),
                 1'($urandom_range(0, 1)));

        for (int k = 0; k < 230; k++)
        begin
            calm = (k >= 120 && k < 180);
            random_command();
        end
        calm = 1'b0;

        // Two sweeps of maximum quantity take from both sides one maker at a time.
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, 32'hFFFF_FFFF, 1'b0);
        send(lobe_pkg::CMD_MATCH, '0, '0, '0, 32'hFFFF_FFFF, 1'b1);

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lobe_pkg.sv
rtl/lobe_req_if.sv
rtl/lobe_rsp_if.sv
rtl/lobe_ctrl.sv
rtl/lobe_dp.sv
rtl/limit_order_book_engine.sv
sim/lobe_checker.sv
sim/tb.sv
